FILE: sv/gpe_pkg.sv
// ----------------------------------------------------------------------------
// gpe_pkg: shared types and constants for the GPIO port with edge interrupts
// Command and register codes, the request and response structures and the
// default pin count.
// ----------------------------------------------------------------------------
package gpe_pkg;

  // default number of pins, at most 16
  localparam int NUM_PINS_DEF = 16;
  localparam int MAX_PINS     = 16;

  // field widths of the request and response
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 32;
  localparam int PINS_W  = 16;
  localparam int NIB_W   = 4;

  // request commands; the spare code behaves as sample only
  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_WRITE  = 2'd2
  } cmd_t;

  // register map
  typedef enum logic [IDX_W-1:0] {
    REG_MODE_LO = 4'd0,
    REG_MODE_HI = 4'd1,
    REG_INPUT   = 4'd2,
    REG_OUTPUT  = 4'd3,
    REG_SET     = 4'd4,
    REG_CLEAR   = 4'd5,
    REG_INTEN   = 4'd6,
    REG_RISE    = 4'd7,
    REG_FALL    = 4'd8,
    REG_PENDING = 4'd9
  } reg_idx_t;

  // one request: pin sample plus optional register access
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] wdata;
    logic [PINS_W-1:0] pins_in;
  } req_t;

  // one response
  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [PINS_W-1:0] pin_drive;
    logic [PINS_W-1:0] pin_output_enable;
    logic [PINS_W-1:0] irq_lines;
    logic              irq_any;
  } rsp_t;

endpackage

FILE: sv/gpe_if.sv
// ----------------------------------------------------------------------------
// gpe_if: request and response channels of the GPIO port
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface gpe_in_if;
  logic                      valid;
  logic                      ready;
  logic [gpe_pkg::CMD_W-1:0]  cmd;
  logic [gpe_pkg::IDX_W-1:0]  reg_index;
  logic [gpe_pkg::DATA_W-1:0] wdata;
  logic [gpe_pkg::PINS_W-1:0] pins_in;

  modport source (output valid, cmd, reg_index, wdata, pins_in, input ready);
  modport sink   (input valid, cmd, reg_index, wdata, pins_in, output ready);
endinterface

interface gpe_out_if;
  logic                      valid;
  logic                      ready;
  logic [gpe_pkg::DATA_W-1:0] rdata;
  logic [gpe_pkg::PINS_W-1:0] pin_drive;
  logic [gpe_pkg::PINS_W-1:0] pin_output_enable;
  logic [gpe_pkg::PINS_W-1:0] irq_lines;
  logic                      irq_any;

  modport source (output valid, rdata, pin_drive, pin_output_enable, irq_lines, irq_any,
                  input ready);
  modport sink   (input valid, rdata, pin_drive, pin_output_enable, irq_lines, irq_any,
                  output ready);
endinterface

FILE: sv/gpio_port_with_edge_interrupts_core.sv
// ----------------------------------------------------------------------------
// gpio_port_with_edge_interrupts_core: 16-pin GPIO port with edge interrupts
// Request/response wrapper around the port register file.
// ----------------------------------------------------------------------------
// Usage
//   in_bus carries one request per transfer: the pad levels to sample and an
//   optional register read or write (cmd, reg_index, wdata). out_bus returns
//   exactly one response per request, in order: read data (zero unless a
//   read), output drive, output enables, masked interrupt lines and their OR.
//   A request is registered on acceptance and passes through the register
//   file once the response register is free; there its response is
//   registered and out_bus valid rises. One request can be accepted
//   every cycle while out_bus is not stalled; the limit is the single
//   pass through the register file.
//   Reset clears all port registers to zero (all pins analog input, nothing
//   pending) and empties both stages. When the receiver stalls the response
//   register holds, the request stage keeps one more request, and in_bus
//   ready then drops until out_bus moves again. Pin sampling and edge
//   detection happen only for accepted requests, in order.
// ----------------------------------------------------------------------------
module gpio_port_with_edge_interrupts_core #(
  parameter int NUM_PINS = gpe_pkg::NUM_PINS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  gpe_in_if.sink           in_bus,
  gpe_out_if.source        out_bus
);
  import gpe_pkg::*;

  logic s1_valid_r;
  req_t s1_req_r;
  logic out_valid_r;
  rsp_t out_rsp_r;
  rsp_t rsp;
  logic advance;
  logic in_take;

  // handshake: stage one moves on when the response register is free
  assign advance      = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || advance;
  assign in_take      = in_bus.valid && in_bus.ready;

  // request stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r.cmd       <= in_bus.cmd;
      s1_req_r.reg_index <= in_bus.reg_index;
      s1_req_r.wdata     <= in_bus.wdata;
      s1_req_r.pins_in   <= in_bus.pins_in;
    end
  end

  // register file and edge logic
  gpe_regs #(
    .NUM_PINS (NUM_PINS)
  ) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (advance),
    .req   (s1_req_r),
    .rsp   (rsp)
  );

  // response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.rdata             = out_rsp_r.rdata;
  assign out_bus.pin_drive         = out_rsp_r.pin_drive;
  assign out_bus.pin_output_enable = out_rsp_r.pin_output_enable;
  assign out_bus.irq_lines         = out_rsp_r.irq_lines;
  assign out_bus.irq_any           = out_rsp_r.irq_any;

  // checks
  a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed request produced no response");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bus.ready && !advance |=> !out_valid_r)
    else $error("response repeated after it was taken");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_req_r))
    else $error("waiting request lost or changed");

endmodule

FILE: sv/gpe_regs.sv
// ----------------------------------------------------------------------------
// gpe_regs: register file and edge detector of the GPIO port
// Holds the port state, detects enabled edges against the previous sample,
// performs the register access and forms the response for one request.
// ----------------------------------------------------------------------------
module gpe_regs #(
  parameter int NUM_PINS = gpe_pkg::NUM_PINS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          upd,
  input  gpe_pkg::req_t req,
  output gpe_pkg::rsp_t rsp
);
  import gpe_pkg::*;

  localparam int MODE_W = NUM_PINS * NIB_W;

  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [NUM_PINS-1:0] out_r, out_nxt;
  logic [NUM_PINS-1:0] in_stat_r;
  logic [NUM_PINS-1:0] inten_r, inten_nxt;
  logic [NUM_PINS-1:0] rise_r, rise_nxt;
  logic [NUM_PINS-1:0] fall_r, fall_nxt;
  logic [NUM_PINS-1:0] pend_r, pend_nxt;

  logic [NUM_PINS-1:0] pins;
  logic [NUM_PINS-1:0] wbits;
  logic [NUM_PINS-1:0] edges;
  logic [NUM_PINS-1:0] oe;
  logic [NUM_PINS-1:0] lines;
  logic [2*DATA_W-1:0] mode_wide;
  logic [2*DATA_W-1:0] mode_wr;
  logic [DATA_W-1:0]   rdata;
  logic                is_rd, is_wr;

  // edge detection against the previous sample
  assign pins  = req.pins_in[NUM_PINS-1:0];
  assign wbits = req.wdata[NUM_PINS-1:0];
  assign edges = (~in_stat_r & pins & rise_r) | (in_stat_r & ~pins & fall_r);
  assign is_rd = (req.cmd == CMD_READ);
  assign is_wr = (req.cmd == CMD_WRITE);
  assign mode_wide = (2*DATA_W)'(mode_r);

  // register read
  always_comb begin
    rdata = '0;
    if (is_rd) begin
      case (req.reg_index)
        REG_MODE_LO: rdata = mode_wide[DATA_W-1:0];
        REG_MODE_HI: rdata = mode_wide[2*DATA_W-1:DATA_W];
        REG_INPUT:   rdata = DATA_W'(pins);
        REG_OUTPUT:  rdata = DATA_W'(out_r);
        REG_INTEN:   rdata = DATA_W'(inten_r);
        REG_RISE:    rdata = DATA_W'(rise_r);
        REG_FALL:    rdata = DATA_W'(fall_r);
        REG_PENDING: rdata = DATA_W'(pend_r | edges);
        default:     rdata = '0;
      endcase
    end
  end

  // register write and pending update; a new edge wins over a clear
  always_comb begin
    mode_wr   = mode_wide;
    out_nxt   = out_r;
    inten_nxt = inten_r;
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    pend_nxt  = pend_r;
    if (is_wr) begin
      case (req.reg_index)
        REG_MODE_LO: mode_wr = {mode_wide[2*DATA_W-1:DATA_W], req.wdata};
        REG_MODE_HI: mode_wr = {req.wdata, mode_wide[DATA_W-1:0]};
        REG_OUTPUT:  out_nxt = wbits;
        REG_SET:     out_nxt = out_r | wbits;
        REG_CLEAR:   out_nxt = out_r & ~wbits;
        REG_INTEN:   inten_nxt = wbits;
        REG_RISE:    rise_nxt = wbits;
        REG_FALL:    fall_nxt = wbits;
        REG_PENDING: pend_nxt = pend_r & ~wbits;
        default:     pend_nxt = pend_r;
      endcase
    end
    pend_nxt = pend_nxt | edges;
    mode_nxt = mode_wr[MODE_W-1:0];
  end

  // output enables from the mode nibbles
  always_comb begin
    for (int i = 0; i < NUM_PINS; i++) begin
      oe[i] = |mode_nxt[i*NIB_W +: 2];
    end
  end

  assign lines = pend_nxt & inten_nxt;

  // response: drive, enables and interrupt lines after this request's updates
  always_comb begin
    rsp.rdata             = rdata;
    rsp.pin_drive         = PINS_W'(out_nxt);
    rsp.pin_output_enable = PINS_W'(oe);
    rsp.irq_lines         = PINS_W'(lines);
    rsp.irq_any           = |lines;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= '0;
      out_r     <= '0;
      in_stat_r <= '0;
      inten_r   <= '0;
      rise_r    <= '0;
      fall_r    <= '0;
      pend_r    <= '0;
    end else if (upd) begin
      mode_r    <= mode_nxt;
      out_r     <= out_nxt;
      in_stat_r <= pins;
      inten_r   <= inten_nxt;
      rise_r    <= rise_nxt;
      fall_r    <= fall_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // checks
  a_sample_taken: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> in_stat_r == $past(pins))
    else $error("input status does not hold the last sample");

  a_pend_cause: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> (pend_r & ~$past(pend_r) & ~($past(rise_r) | $past(fall_r))) == '0)
    else $error("pending bit set on a pin with no edge enable");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable(pend_r) && $stable(out_r) && $stable(in_stat_r))
    else $error("state changed without a request");

endmodule
